### hw/rtl/unordered_set_table_defines.svh
// Assertion macros for the set table checker.
`ifndef UNORDERED_SET_TABLE_DEFINES_SVH
`define UNORDERED_SET_TABLE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UST_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define UST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/ust_pkg.sv
// Shared types and codes for the unordered set table.
package ust_pkg;

	localparam int LIMIT_W     = 7;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd50;

	localparam logic [2:0] OP_INSERT = 3'd0;
	localparam logic [2:0] OP_DELETE = 3'd1;
	localparam logic [2:0] OP_FIND   = 3'd2;
	localparam logic [2:0] OP_GET    = 3'd3;
	localparam logic [2:0] OP_CLEAR  = 3'd4;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_FULL    = 3'd1;
	localparam logic [2:0] ST_DUP     = 3'd2;
	localparam logic [2:0] ST_MISSING = 3'd3;
	localparam logic [2:0] ST_RANGE   = 3'd4;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [31:0] key;
		logic [5:0]  slot_index;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [5:0]  found_slot;
		logic [31:0] read_value;
		logic [6:0]  entry_count;
		logic        is_full;
		logic        is_empty;
	} rsp_t;

	// Controller to datapath
	typedef struct packed {
		logic       load;
		logic       scan_start;
		logic       scan_step;
		logic       rd_last;
		logic       rd_get;
		logic       res_set;
		logic       res_hit;
		logic       ins_write;
		logic       del_write;
		logic       get_done;
		logic       clear;
		logic       emit;
		logic [2:0] status;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [2:0] op;
		logic       full;
		logic       hit;
		logic       miss;
		logic       out_free;
	} sts_t;

endpackage

### hw/rtl/ust_if.sv
// Request, result and configuration channel interfaces.
interface ust_req_if import ust_pkg::*;;
	logic valid;
	logic ready;
	req_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface ust_rsp_if import ust_pkg::*;;
	logic valid;
	logic ready;
	rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface ust_cfg_if import ust_pkg::*;;
	logic               valid;
	logic               ready;
	logic [LIMIT_W-1:0] wdata;
	modport source (output valid, output wdata, input ready);
	modport sink (input valid, input wdata, output ready);
endinterface

### hw/rtl/ust_ram.sv
// Generic single write port, single read port RAM with registered read.
module ust_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/ust_dpath.sv
// Datapath: entry store, count, scan pointer, result and output registers.
module ust_dpath import ust_pkg::*; #(
	parameter int DEPTH     = 64,
	parameter int KEY_WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  req_t          req_payload,
	input  cmd_t          cmd,
	output sts_t          sts,
	ust_rsp_if.source     rsp,
	ust_cfg_if.sink       cfg
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
	localparam int XW = (CW > 6) ? CW : 6;

	logic [2:0]           op_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [5:0]           idx_q;
	logic [IW-1:0]        slot_q;
	logic [CW-1:0]        count_q;
	logic [LIMIT_W-1:0]   limit_q;
	logic [CW-1:0]        ptr_q;
	logic                 pend_s1;
	logic [IW-1:0]        addr_s1;
	logic [2:0]           res_status_q;
	logic [IW-1:0]        res_slot_q;
	logic [KEY_WIDTH-1:0] res_rv_q;
	rsp_t                 out_q;
	logic                 out_valid_q;

	logic                 ram_we;
	logic [IW-1:0]        ram_waddr;
	logic [KEY_WIDTH-1:0] ram_wdata;
	logic [IW-1:0]        ram_raddr;
	logic [KEY_WIDTH-1:0] ram_rdata;

	logic                 full;
	logic                 in_range;
	logic                 issue;

	ust_ram #(
		.WIDTH (KEY_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Limit above DEPTH saturates, so count at DEPTH is always full
	assign full     = (LW'(count_q) >= LW'(limit_q)) || (count_q == CW'(DEPTH));
	assign in_range = XW'(idx_q) < XW'(count_q);
	assign issue    = ptr_q != count_q;

	always_comb begin
		ram_raddr = IW'(ptr_q);
		if (cmd.rd_last) begin
			ram_raddr = IW'(count_q - CW'(1));
		end else if (cmd.rd_get) begin
			ram_raddr = in_range ? IW'(idx_q) : '0;
		end
	end

	always_comb begin
		ram_we    = cmd.ins_write || cmd.del_write;
		ram_waddr = cmd.del_write ? slot_q : IW'(count_q);
		ram_wdata = cmd.del_write ? ram_rdata : key_q;
	end

	assign sts.op       = op_q;
	assign sts.full     = full;
	assign sts.hit      = pend_s1 && (ram_rdata == key_q);
	assign sts.miss     = !pend_s1 && !issue;
	assign sts.out_free = !out_valid_q || rsp.ready;

	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;
	assign cfg.ready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			limit_q     <= LIMIT_RESET;
			ptr_q       <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				limit_q <= cfg.wdata;
			end
			if (cmd.scan_start) begin
				ptr_q   <= '0;
				pend_s1 <= 1'b0;
			end else if (cmd.scan_step) begin
				pend_s1 <= issue;
				if (issue) begin
					ptr_q <= ptr_q + CW'(1);
				end
			end
			if (cmd.ins_write) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.del_write) begin
				count_q <= count_q - CW'(1);
			end else if (cmd.clear) begin
				count_q <= '0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= req_payload.opcode;
			key_q <= KEY_WIDTH'(req_payload.key);
			idx_q <= req_payload.slot_index;
		end
		if (cmd.scan_step) begin
			addr_s1 <= IW'(ptr_q);
		end
		// Hold the matching slot while the last entry is fetched
		if (cmd.rd_last) begin
			slot_q <= addr_s1;
		end
		if (cmd.res_set) begin
			res_status_q <= cmd.status;
			res_slot_q   <= '0;
			res_rv_q     <= '0;
		end else if (cmd.res_hit) begin
			res_status_q <= cmd.status;
			res_slot_q   <= addr_s1;
			res_rv_q     <= '0;
		end else if (cmd.ins_write) begin
			res_status_q <= ST_OK;
			res_slot_q   <= IW'(count_q);
			res_rv_q     <= '0;
		end else if (cmd.del_write) begin
			res_status_q <= ST_OK;
			res_slot_q   <= slot_q;
			res_rv_q     <= '0;
		end else if (cmd.get_done) begin
			res_status_q <= in_range ? ST_OK : ST_RANGE;
			res_slot_q   <= '0;
			res_rv_q     <= (in_range || count_q != '0) ? ram_rdata : '0;
		end
		if (cmd.emit) begin
			out_q.status      <= res_status_q;
			out_q.found_slot  <= 6'(res_slot_q);
			out_q.read_value  <= 32'(res_rv_q);
			out_q.entry_count <= 7'(count_q);
			out_q.is_full     <= full;
			out_q.is_empty    <= count_q == '0;
		end
	end

endmodule

### hw/rtl/ust_ctrl.sv
// Controller: sequences each request through decode, then scan, move or get as needed, then result.
module ust_ctrl import ust_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_LAST,
		S_GET,
		S_RESULT
	} state_t;

	state_t state_q;
	state_t state_d;

	assign req_ready = state_q == S_IDLE;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (sts.op) inside
					OP_INSERT: begin
						if (sts.full) begin
							cmd.res_set = 1'b1;
							cmd.status  = ST_FULL;
							state_d     = S_RESULT;
						end else begin
							cmd.scan_start = 1'b1;
							state_d        = S_SCAN;
						end
					end
					OP_DELETE, OP_FIND: begin
						cmd.scan_start = 1'b1;
						state_d        = S_SCAN;
					end
					OP_GET: begin
						cmd.rd_get = 1'b1;
						state_d    = S_GET;
					end
					OP_CLEAR: begin
						cmd.clear   = 1'b1;
						cmd.res_set = 1'b1;
						cmd.status  = ST_OK;
						state_d     = S_RESULT;
					end
					default: begin
						cmd.res_set = 1'b1;
						cmd.status  = ST_OK;
						state_d     = S_RESULT;
					end
				endcase
			end
			S_SCAN: begin
				if (sts.hit) begin
					if (sts.op == OP_INSERT) begin
						cmd.res_hit = 1'b1;
						cmd.status  = ST_DUP;
						state_d     = S_RESULT;
					end else if (sts.op == OP_DELETE) begin
						// fetch the last entry to fill the freed slot
						cmd.rd_last = 1'b1;
						state_d     = S_LAST;
					end else begin
						cmd.res_hit = 1'b1;
						cmd.status  = ST_OK;
						state_d     = S_RESULT;
					end
				end else if (sts.miss) begin
					if (sts.op == OP_INSERT) begin
						cmd.ins_write = 1'b1;
					end else begin
						cmd.res_set = 1'b1;
						cmd.status  = ST_MISSING;
					end
					state_d = S_RESULT;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_LAST: begin
				cmd.del_write = 1'b1;
				state_d       = S_RESULT;
			end
			S_GET: begin
				cmd.get_done = 1'b1;
				state_d      = S_RESULT;
			end
			S_RESULT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### hw/rtl/unordered_set_table.sv
// Top level of the unordered set table: controller, datapath and entry RAM.
// Insert, delete and find scan entries from slot 0 until a hit or the end of the count; a
// delete hit then moves the last entry into the freed slot. Get-at reads the addressed slot;
// clear, full insert and unused opcodes go straight to the result, held while output stalls.
// Throughput: one request at a time; the next is taken only after the result is loaded.
// Reset empties the table and sets the capacity limit to 50; entries stay as they were.
module unordered_set_table import ust_pkg::*; #(
	parameter int DEPTH     = 64,
	parameter int KEY_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	ust_req_if.sink   req,
	ust_rsp_if.source rsp,
	ust_cfg_if.sink   cfg
);

	cmd_t cmd;
	sts_t sts;
	logic ready;

	assign req.ready = ready;

	ust_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ust_dpath #(
		.DEPTH     (DEPTH),
		.KEY_WIDTH (KEY_WIDTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_payload (req.payload),
		.cmd         (cmd),
		.sts         (sts),
		.rsp         (rsp),
		.cfg         (cfg)
	);

endmodule

### hw/rtl/ust_checker.sv
// Port-level checker for the unordered set table, bound to the top level.
`include "unordered_set_table_defines.svh"

module ust_checker import ust_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp_payload
);

	`UST_ASSERT_NEXT(a_busy_after_req, clk, arst_n, req_valid && req_ready, !req_ready, "request taken while busy")
	`UST_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "result dropped or changed while stalled")
	`UST_ASSERT_NOW(a_empty_flag, clk, arst_n, rsp_valid, rsp_payload.is_empty == (rsp_payload.entry_count == 7'd0), "empty flag disagrees with count")
	`UST_ASSERT_NOW(a_full_status, clk, arst_n, rsp_valid && rsp_payload.status == ST_FULL, rsp_payload.is_full, "full status without full flag")

endmodule

bind unordered_set_table ust_checker u_ust_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_payload (rsp.payload)
);
